@@ design/jcse_pkg.sv @@
// Shared types, constants and helpers for the JTAG command shift engine.
package jcse_pkg;

    localparam int CLOCK_COUNT_WIDTH_DEF = 32;

    localparam logic [7:0] CMD_VERSION      = 8'd101;
    localparam logic [7:0] CMD_MOVE         = 8'd102;
    localparam logic [7:0] CMD_LOAD_IGNORE  = 8'd103;
    localparam logic [7:0] CMD_LOAD_CAPTURE = 8'd104;
    localparam logic [7:0] CMD_CLOCK        = 8'd105;

    localparam logic [3:0] STEP_MAIN = 4'd6;
    localparam logic [4:0] VERSION_LAST = 5'd16;

    typedef enum logic [3:0] {
        PH_IDLE         = 4'd0,
        PH_MOVE_COUNT   = 4'd1,
        PH_MOVE_PATTERN = 4'd2,
        PH_LOAD_COUNT   = 4'd3,
        PH_LOAD_RUN     = 4'd4,
        PH_CLK_RETRY    = 4'd5,
        PH_CLK_COUNT    = 4'd6,
        PH_MOVE_RUN     = 4'd7,
        PH_CLK_RUN      = 4'd8
    } phase_t;

    typedef struct packed {
        logic       func;
        logic [7:0] host_byte;
        logic       packet_end;
        logic       tdo;
    } req_t;

    typedef struct packed {
        logic       clock_valid;
        logic       tms;
        logic       tdi;
        logic       reply_valid;
        logic [7:0] reply_byte;
        logic       reply_last;
    } rsp_t;

    typedef struct packed {
        logic valid;
        logic is_tick;
        req_t item;
    } queue_head_t;

    function automatic logic [7:0] version_byte(input logic [4:0] idx);
        logic [7:0] b;
        case (idx)
            5'd0:    b = 8'h31;
            5'd1:    b = 8'h4A;
            5'd2:    b = 8'h65;
            5'd3:    b = 8'h6B;
            5'd4:    b = 8'h74;
            5'd5:    b = 8'h6F;
            5'd6:    b = 8'h72;
            5'd16:   b = 8'h00;
            default: b = 8'h20;
        endcase
        return b;
    endfunction

    function automatic logic retry_prefix(input logic [3:0] step);
        logic t;
        case (step)
            4'd1, 4'd3, 4'd4: t = 1'b1;
            default:          t = 1'b0;
        endcase
        return t;
    endfunction

endpackage

@@ design/jcse_front.sv @@
// Front end: two-entry request queue that tags ticks and host bytes.
module jcse_front (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                req_valid,
    output logic                req_ready,
    input  jcse_pkg::req_t      req,
    output jcse_pkg::queue_head_t head,
    input  logic                pop
);

    jcse_pkg::req_t mem [2];
    logic       wr_ptr_reg, wr_ptr_next;
    logic       rd_ptr_reg, rd_ptr_next;
    logic [1:0] count_reg, count_next;
    logic       push;

    assign req_ready = (count_reg != 2'd2);
    assign push      = req_valid && req_ready;

    assign head.valid   = (count_reg != 2'd0);
    assign head.item    = mem[rd_ptr_reg];
    assign head.is_tick = mem[rd_ptr_reg].func;

    always_comb
    begin
        wr_ptr_next = push ? ~wr_ptr_reg : wr_ptr_reg;
        rd_ptr_next = pop ? ~rd_ptr_reg : rd_ptr_reg;
        count_next  = count_reg + {1'b0, push} - {1'b0, pop};
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem[wr_ptr_reg] <= req;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

endmodule

@@ design/jcse_back.sv @@
// Back end: command parser, JTAG sequencer and response register.
module jcse_back #(
    parameter int CLOCK_COUNT_WIDTH = jcse_pkg::CLOCK_COUNT_WIDTH_DEF
) (
    input  logic                  clk,
    input  logic                  rst_n,
    input  jcse_pkg::queue_head_t head,
    output logic                  pop,
    input  logic                  count_big_endian,
    output logic                  rsp_valid,
    input  logic                  rsp_ready,
    output jcse_pkg::rsp_t        rsp
);

    localparam logic [63:0] MASK64 = (64'd1 << CLOCK_COUNT_WIDTH) - 64'd1;
    localparam logic [31:0] CNT_MASK = MASK64[31:0];
    localparam logic [3:0] STEP_MAIN_P1 = jcse_pkg::STEP_MAIN + 4'd1;

    jcse_pkg::phase_t phase_reg, phase_next;
    logic [2:0]  arg_reg, arg_next;
    logic [31:0] bits_reg, bits_next;
    logic [7:0]  pat_reg, pat_next;
    logic [7:0]  data_reg, data_next;
    logic [2:0]  bp_reg, bp_next;
    logic [7:0]  capb_reg, capb_next;
    logic        tdi_reg, tdi_next;
    logic        tms_reg, tms_next;
    logic        cap_reg, cap_next;
    logic        retry_reg, retry_next;
    logic [3:0]  step_reg, step_next;
    logic        need_reg, need_next;
    logic        skip_reg, skip_next;
    logic        ver_busy_reg, ver_busy_next;
    logic [4:0]  ver_idx_reg, ver_idx_next;
    logic        rsp_valid_reg, rsp_valid_next;
    jcse_pkg::rsp_t rsp_reg, rsp_next;

    logic        slot_free;
    logic        res_valid, res_clk, res_rv, res_last, start_ver, done;
    logic [7:0]  res_byte;
    logic [31:0] cnt;
    logic [31:0] cnt_m;
    logic [7:0]  bmask;
    logic [3:0]  s;
    jcse_pkg::req_t it;

    assign slot_free = !rsp_valid_reg || rsp_ready;
    assign pop       = head.valid && !ver_busy_reg && slot_free;
    assign it        = head.item;
    assign rsp_valid = rsp_valid_reg;
    assign rsp       = rsp_reg;

    always_comb
    begin
        phase_next = phase_reg;
        arg_next   = arg_reg;
        bits_next  = bits_reg;
        pat_next   = pat_reg;
        data_next  = data_reg;
        bp_next    = bp_reg;
        capb_next  = capb_reg;
        tdi_next   = tdi_reg;
        tms_next   = tms_reg;
        cap_next   = cap_reg;
        retry_next = retry_reg;
        step_next  = step_reg;
        need_next  = need_reg;
        skip_next  = skip_reg;
        res_valid  = 1'b0;
        res_clk    = 1'b0;
        res_rv     = 1'b0;
        res_last   = 1'b0;
        res_byte   = 8'd0;
        start_ver  = 1'b0;
        done       = 1'b0;
        bmask      = 8'd1 << bp_reg;
        s          = step_reg - STEP_MAIN_P1;
        if (count_big_endian)
        begin
            cnt = {bits_reg[23:0], it.host_byte};
        end
        else
        begin
            cnt = bits_reg | ({24'd0, it.host_byte} << {arg_reg[1:0], 3'b000});
        end
        cnt_m = cnt & CNT_MASK;

        if (head.is_tick)
        begin
            case (phase_reg)
                jcse_pkg::PH_MOVE_RUN:
                begin
                    tms_next  = pat_reg[0];
                    pat_next  = pat_reg >> 1;
                    bits_next = bits_reg - 32'd1;
                    if (bits_next == 32'd0)
                    begin
                        phase_next = jcse_pkg::PH_IDLE;
                    end
                    res_valid = 1'b1;
                    res_clk   = 1'b1;
                end
                jcse_pkg::PH_LOAD_RUN:
                begin
                    if (!need_reg && bits_reg != 32'd0)
                    begin
                        bits_next = bits_reg - 32'd1;
                        tms_next  = (bits_next == 32'd0);
                        tdi_next  = |(data_reg & bmask);
                        if (cap_reg)
                        begin
                            capb_next = it.tdo ? (capb_reg | bmask) : (capb_reg & ~bmask);
                            if (bits_next == 32'd0 || bp_reg == 3'd7)
                            begin
                                res_rv   = 1'b1;
                                res_last = (bits_next == 32'd0);
                                res_byte = capb_next;
                            end
                        end
                        res_valid = 1'b1;
                        res_clk   = 1'b1;
                        if (bits_next == 32'd0)
                        begin
                            phase_next = jcse_pkg::PH_IDLE;
                        end
                        else if (bp_reg == 3'd7)
                        begin
                            bp_next   = 3'd0;
                            need_next = 1'b1;
                        end
                        else
                        begin
                            bp_next = bp_reg + 3'd1;
                        end
                    end
                end
                jcse_pkg::PH_CLK_RUN:
                begin
                    if (step_reg < jcse_pkg::STEP_MAIN)
                    begin
                        tms_next  = jcse_pkg::retry_prefix(step_reg);
                        step_next = step_reg + 4'd1;
                        if (step_next == jcse_pkg::STEP_MAIN && bits_reg == 32'd0)
                        begin
                            step_next = STEP_MAIN_P1;
                        end
                    end
                    else if (step_reg == jcse_pkg::STEP_MAIN)
                    begin
                        tms_next = 1'b0;
                        if (bits_reg != 32'd0)
                        begin
                            bits_next = bits_reg - 32'd1;
                        end
                        if (bits_next == 32'd0)
                        begin
                            if (retry_reg)
                            begin
                                step_next = STEP_MAIN_P1;
                            end
                            else
                            begin
                                done = 1'b1;
                            end
                        end
                    end
                    else
                    begin
                        tms_next  = (s == 4'd0);
                        step_next = step_reg + 4'd1;
                        if (s >= 4'd2)
                        begin
                            done = 1'b1;
                        end
                    end
                    if (done)
                    begin
                        phase_next = jcse_pkg::PH_IDLE;
                        step_next  = 4'd0;
                        res_rv     = 1'b1;
                        res_last   = 1'b1;
                    end
                    res_valid = 1'b1;
                    res_clk   = 1'b1;
                end
                default:
                begin
                end
            endcase
        end
        else if (skip_reg)
        begin
            if (it.packet_end)
            begin
                skip_next = 1'b0;
            end
        end
        else
        begin
            case (phase_reg)
                jcse_pkg::PH_IDLE:
                begin
                    arg_next  = 3'd0;
                    bits_next = 32'd0;
                    case (it.host_byte)
                        jcse_pkg::CMD_VERSION:
                        begin
                            skip_next = !it.packet_end;
                            start_ver = 1'b1;
                        end
                        jcse_pkg::CMD_MOVE:
                        begin
                            phase_next = jcse_pkg::PH_MOVE_COUNT;
                        end
                        jcse_pkg::CMD_LOAD_IGNORE, jcse_pkg::CMD_LOAD_CAPTURE:
                        begin
                            cap_next   = (it.host_byte == jcse_pkg::CMD_LOAD_CAPTURE);
                            phase_next = jcse_pkg::PH_LOAD_COUNT;
                        end
                        jcse_pkg::CMD_CLOCK:
                        begin
                            phase_next = jcse_pkg::PH_CLK_RETRY;
                        end
                        default:
                        begin
                            skip_next = !it.packet_end;
                        end
                    endcase
                end
                jcse_pkg::PH_MOVE_COUNT:
                begin
                    bits_next  = {24'd0, it.host_byte};
                    phase_next = jcse_pkg::PH_MOVE_PATTERN;
                end
                jcse_pkg::PH_MOVE_PATTERN:
                begin
                    pat_next   = it.host_byte;
                    skip_next  = !it.packet_end;
                    phase_next = (bits_reg != 32'd0) ? jcse_pkg::PH_MOVE_RUN
                                                     : jcse_pkg::PH_IDLE;
                end
                jcse_pkg::PH_LOAD_COUNT:
                begin
                    arg_next  = arg_reg + 3'd1;
                    bits_next = cnt;
                    if (arg_next >= 3'd2)
                    begin
                        bits_next  = {16'd0, cnt[15:0]};
                        phase_next = jcse_pkg::PH_LOAD_RUN;
                        need_next  = 1'b1;
                        bp_next    = 3'd0;
                        capb_next  = 8'd0;
                        tms_next   = 1'b0;
                    end
                end
                jcse_pkg::PH_LOAD_RUN:
                begin
                    if (need_reg)
                    begin
                        data_next = it.host_byte;
                        need_next = 1'b0;
                        if (bits_reg <= 32'd8)
                        begin
                            skip_next = !it.packet_end;
                        end
                        if (bits_reg == 32'd0)
                        begin
                            phase_next = jcse_pkg::PH_IDLE;
                        end
                    end
                end
                jcse_pkg::PH_CLK_RETRY:
                begin
                    retry_next = (it.host_byte != 8'd0);
                    phase_next = jcse_pkg::PH_CLK_COUNT;
                end
                jcse_pkg::PH_CLK_COUNT:
                begin
                    arg_next  = arg_reg + 3'd1;
                    bits_next = cnt;
                    if (arg_next >= 3'd4)
                    begin
                        skip_next = !it.packet_end;
                        tms_next  = 1'b0;
                        if (retry_reg)
                        begin
                            bits_next  = (cnt_m != 32'd0) ? cnt_m - 32'd1 : 32'd0;
                            step_next  = 4'd0;
                            phase_next = jcse_pkg::PH_CLK_RUN;
                        end
                        else if (cnt_m == 32'd0)
                        begin
                            bits_next  = 32'd0;
                            phase_next = jcse_pkg::PH_IDLE;
                            res_valid  = 1'b1;
                            res_rv     = 1'b1;
                            res_last   = 1'b1;
                        end
                        else
                        begin
                            bits_next  = cnt_m;
                            step_next  = jcse_pkg::STEP_MAIN;
                            phase_next = jcse_pkg::PH_CLK_RUN;
                        end
                    end
                end
                default:
                begin
                end
            endcase
        end
    end

    always_comb
    begin
        rsp_valid_next = rsp_valid_reg && !rsp_ready;
        rsp_next       = rsp_reg;
        ver_busy_next  = ver_busy_reg;
        ver_idx_next   = ver_idx_reg;
        if (pop)
        begin
            if (start_ver)
            begin
                rsp_valid_next = 1'b1;
                rsp_next       = '{1'b0, tms_reg, tdi_reg, 1'b1,
                                   jcse_pkg::version_byte(5'd0), 1'b0};
                ver_busy_next  = 1'b1;
                ver_idx_next   = 5'd1;
            end
            else if (res_valid)
            begin
                rsp_valid_next = 1'b1;
                rsp_next       = '{res_clk, tms_next, tdi_next, res_rv, res_byte, res_last};
            end
        end
        else if (ver_busy_reg && slot_free)
        begin
            rsp_valid_next = 1'b1;
            rsp_next       = '{1'b0, tms_reg, tdi_reg, 1'b1,
                               jcse_pkg::version_byte(ver_idx_reg),
                               ver_idx_reg == jcse_pkg::VERSION_LAST};
            ver_idx_next   = ver_idx_reg + 5'd1;
            if (ver_idx_reg == jcse_pkg::VERSION_LAST)
            begin
                ver_busy_next = 1'b0;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg     <= jcse_pkg::PH_IDLE;
            arg_reg       <= 3'd0;
            bits_reg      <= 32'd0;
            pat_reg       <= 8'd0;
            data_reg      <= 8'd0;
            bp_reg        <= 3'd0;
            capb_reg      <= 8'd0;
            tdi_reg       <= 1'b0;
            tms_reg       <= 1'b0;
            cap_reg       <= 1'b0;
            retry_reg     <= 1'b0;
            step_reg      <= 4'd0;
            need_reg      <= 1'b0;
            skip_reg      <= 1'b0;
            ver_busy_reg  <= 1'b0;
            ver_idx_reg   <= 5'd0;
            rsp_valid_reg <= 1'b0;
            rsp_reg       <= '0;
        end
        else
        begin
            if (pop)
            begin
                phase_reg <= phase_next;
                arg_reg   <= arg_next;
                bits_reg  <= bits_next;
                pat_reg   <= pat_next;
                data_reg  <= data_next;
                bp_reg    <= bp_next;
                capb_reg  <= capb_next;
                tdi_reg   <= tdi_next;
                tms_reg   <= tms_next;
                cap_reg   <= cap_next;
                retry_reg <= retry_next;
                step_reg  <= step_next;
                need_reg  <= need_next;
                skip_reg  <= skip_next;
            end
            ver_busy_reg  <= ver_busy_next;
            ver_idx_reg   <= ver_idx_next;
            rsp_valid_reg <= rsp_valid_next;
            rsp_reg       <= rsp_next;
        end
    end

    a_no_pop_in_burst: assert property (@(posedge clk) disable iff (!rst_n)
        ver_busy_reg |-> !pop)
        else $error("request taken during version reply");

    a_burst_index: assert property (@(posedge clk) disable iff (!rst_n)
        ver_busy_reg |-> (ver_idx_reg != 5'd0 && ver_idx_reg <= jcse_pkg::VERSION_LAST))
        else $error("version index out of range");

    a_step_range: assert property (@(posedge clk) disable iff (!rst_n)
        step_reg <= 4'd10)
        else $error("sequence step out of range");

    a_last_has_reply: assert property (@(posedge clk) disable iff (!rst_n)
        (rsp_valid_reg && rsp_reg.reply_last) |-> rsp_reg.reply_valid)
        else $error("reply_last without reply");

    a_burst_ends: assert property (@(posedge clk) disable iff (!rst_n)
        (ver_busy_reg && !ver_busy_next) |-> (ver_idx_reg == jcse_pkg::VERSION_LAST))
        else $error("version reply ended early");

endmodule

@@ design/jtag_command_shift_engine.sv @@
// Top level of the JTAG command shift engine.
//
//  channel | direction | handshake               | payload
//  req     | in        | req_valid / req_ready   | jcse_pkg::req_t (tick or host byte)
//  rsp     | out       | rsp_valid / rsp_ready   | jcse_pkg::rsp_t (TCK cycle or reply byte)
//  cfg     | in        | cfg_we                  | cfg_wdata (count_big_endian)
//
// One request per cycle unless a version reply or a stalled response holds the back end;
// a version command gives a 17-byte reply, any other request at most one response.
// A response is registered: a taken request passes through the queue, then the response register.
// Reset leaves the engine idle with count_big_endian set.
// Either side may stall; while responses stall, the two-entry queue holds up to two requests.
module jtag_command_shift_engine #(
    parameter int CLOCK_COUNT_WIDTH = jcse_pkg::CLOCK_COUNT_WIDTH_DEF
) (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           req_valid,
    output logic           req_ready,
    input  jcse_pkg::req_t req,
    output logic           rsp_valid,
    input  logic           rsp_ready,
    output jcse_pkg::rsp_t rsp,
    input  logic           cfg_we,
    input  logic           cfg_wdata
);

    jcse_pkg::queue_head_t head;
    logic                  pop;
    logic                  cbe_reg, cbe_next;

    assign cbe_next = cfg_we ? cfg_wdata : cbe_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cbe_reg <= 1'b1;
        end
        else
        begin
            cbe_reg <= cbe_next;
        end
    end

    jcse_front u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req_valid),
        .req_ready (req_ready),
        .req       (req),
        .head      (head),
        .pop       (pop)
    );

    jcse_back #(
        .CLOCK_COUNT_WIDTH (CLOCK_COUNT_WIDTH)
    ) u_back (
        .clk              (clk),
        .rst_n            (rst_n),
        .head             (head),
        .pop              (pop),
        .count_big_endian (cbe_reg),
        .rsp_valid        (rsp_valid),
        .rsp_ready        (rsp_ready),
        .rsp              (rsp)
    );

endmodule

@@ tb/testbench.sv @@
// Self-checking testbench for the JTAG command shift engine: random and directed command streams.
`timescale 1ns / 1ps

module testbench;

    localparam int LIMIT_CYCLES = 400000;
    localparam int STALL_CYCLES = 300;

    logic clk;
    logic rst_n;
    logic req_valid;
    logic req_ready;
    jcse_pkg::req_t req;
    logic rsp_valid;
    logic rsp_ready;
    jcse_pkg::rsp_t rsp;
    logic cfg_we;
    logic cfg_wdata;

    jtag_command_shift_engine u_dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .req_valid(req_valid),
        .req_ready(req_ready),
        .req      (req),
        .rsp_valid(rsp_valid),
        .rsp_ready(rsp_ready),
        .rsp      (rsp),
        .cfg_we   (cfg_we),
        .cfg_wdata(cfg_wdata)
    );

    // engine model state
    logic             m_big_endian;
    jcse_pkg::phase_t m_phase;
    logic [2:0]       m_arg_idx;
    logic [31:0]      m_bits_left;
    logic [7:0]       m_tms_pat;
    logic [7:0]       m_data;
    logic [2:0]       m_bit_pos;
    logic [7:0]       m_capture;
    logic             m_tdi;
    logic             m_tms;
    logic             m_capture_on;
    logic             m_retry_on;
    logic [3:0]       m_seq_step;
    logic             m_need_byte;
    logic             m_skip;

    jcse_pkg::rsp_t expected_rsp_q[$];
    int     errors;
    int     cycle_count;
    logic   stall_hold;
    logic   idle_enable;

    always
    begin
        #4 clk = 1'b1;
        #4 clk = 1'b0;
    end

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= LIMIT_CYCLES)
        begin
            $display("testbench NOT OK");
            $finish;
        end
    end

    function automatic logic [7:0] ver_char(input int i);
        logic [7:0] t[17];
        t = '{8'h31, 8'h4A, 8'h65, 8'h6B, 8'h74, 8'h6F, 8'h72, 8'h20, 8'h20,
              8'h20, 8'h20, 8'h20, 8'h20, 8'h20, 8'h20, 8'h20, 8'h00};
        return t[i];
    endfunction

    task automatic push_rsp(input logic cv, input logic rv, input logic [7:0] rb,
                            input logic rl);
        jcse_pkg::rsp_t r;
        r.clock_valid = cv;
        r.tms = m_tms;
        r.tdi = m_tdi;
        r.reply_valid = rv;
        r.reply_byte = rb;
        r.reply_last = rl;
        expected_rsp_q.push_back(r);
    endtask

    task automatic model_reset();
        m_big_endian = 1'b1;
        m_phase = jcse_pkg::PH_IDLE;
        m_arg_idx = '0;
        m_bits_left = '0;
        m_tms_pat = '0;
        m_data = '0;
        m_bit_pos = '0;
        m_capture = '0;
        m_tdi = 1'b0;
        m_tms = 1'b0;
        m_capture_on = 1'b0;
        m_retry_on = 1'b0;
        m_seq_step = '0;
        m_need_byte = 1'b0;
        m_skip = 1'b0;
    endtask

    task automatic take_count(input logic [7:0] b);
        if (m_big_endian)
            m_bits_left = (m_bits_left << 8) | 32'(b);
        else
            m_bits_left = m_bits_left | (32'(b) << (8 * m_arg_idx[1:0]));
        m_arg_idx = m_arg_idx + 3'd1;
    endtask

    task automatic model_host_byte(input logic [7:0] b, input logic pend);
        if (m_skip)
        begin
            if (pend)
                m_skip = 1'b0;
            return;
        end
        case (m_phase)
            jcse_pkg::PH_IDLE:
            begin
                m_arg_idx = '0;
                m_bits_left = '0;
                if (b == jcse_pkg::CMD_VERSION)
                begin
                    m_skip = !pend;
                    for (int i = 0; i < 17; i++)
                        push_rsp(1'b0, 1'b1, ver_char(i), i == 16);
                end
                else if (b == jcse_pkg::CMD_MOVE)
                    m_phase = jcse_pkg::PH_MOVE_COUNT;
                else if (b == jcse_pkg::CMD_LOAD_IGNORE || b == jcse_pkg::CMD_LOAD_CAPTURE)
                begin
                    m_capture_on = (b == jcse_pkg::CMD_LOAD_CAPTURE);
                    m_phase = jcse_pkg::PH_LOAD_COUNT;
                end
                else if (b == jcse_pkg::CMD_CLOCK)
                    m_phase = jcse_pkg::PH_CLK_RETRY;
                else
                    m_skip = !pend;
            end
            jcse_pkg::PH_MOVE_COUNT:
            begin
                m_bits_left = 32'(b);
                m_phase = jcse_pkg::PH_MOVE_PATTERN;
            end
            jcse_pkg::PH_MOVE_PATTERN:
            begin
                m_tms_pat = b;
                m_skip = !pend;
                m_phase = (m_bits_left != 0) ? jcse_pkg::PH_MOVE_RUN : jcse_pkg::PH_IDLE;
            end
            jcse_pkg::PH_LOAD_COUNT:
            begin
                take_count(b);
                if (m_arg_idx >= 2)
                begin
                    m_bits_left = m_bits_left & 32'hFFFF;
                    m_phase = jcse_pkg::PH_LOAD_RUN;
                    m_need_byte = 1'b1;
                    m_bit_pos = '0;
                    m_capture = '0;
                    m_tms = 1'b0;
                end
            end
            jcse_pkg::PH_LOAD_RUN:
            begin
                if (m_need_byte)
                begin
                    m_data = b;
                    m_need_byte = 1'b0;
                    if (m_bits_left <= 8)
                        m_skip = !pend;
                    if (m_bits_left == 0)
                        m_phase = jcse_pkg::PH_IDLE;
                end
            end
            jcse_pkg::PH_CLK_RETRY:
            begin
                m_retry_on = (b != 0);
                m_phase = jcse_pkg::PH_CLK_COUNT;
            end
            jcse_pkg::PH_CLK_COUNT:
            begin
                take_count(b);
                if (m_arg_idx >= 4)
                begin
                    m_skip = !pend;
                    m_tms = 1'b0;
                    if (m_retry_on)
                    begin
                        if (m_bits_left != 0)
                            m_bits_left = m_bits_left - 1;
                        m_seq_step = '0;
                        m_phase = jcse_pkg::PH_CLK_RUN;
                    end
                    else if (m_bits_left == 0)
                    begin
                        m_phase = jcse_pkg::PH_IDLE;
                        push_rsp(1'b0, 1'b1, 8'h00, 1'b1);
                    end
                    else
                    begin
                        m_seq_step = jcse_pkg::STEP_MAIN;
                        m_phase = jcse_pkg::PH_CLK_RUN;
                    end
                end
            end
            default: ;
        endcase
    endtask

    task automatic model_tick(input logic tdo);
        logic [7:0] mask;
        logic       rv;
        logic       done;
        int         s;
        rv = 1'b0;
        done = 1'b0;
        case (m_phase)
            jcse_pkg::PH_MOVE_RUN:
            begin
                m_tms = m_tms_pat[0];
                m_tms_pat = m_tms_pat >> 1;
                m_bits_left = m_bits_left - 1;
                if (m_bits_left == 0)
                    m_phase = jcse_pkg::PH_IDLE;
                push_rsp(1'b1, 1'b0, 8'h00, 1'b0);
            end
            jcse_pkg::PH_LOAD_RUN:
            begin
                if (!m_need_byte && m_bits_left != 0)
                begin
                    m_bits_left = m_bits_left - 1;
                    mask = 8'h01 << m_bit_pos;
                    m_tms = (m_bits_left == 0);
                    m_tdi = (m_data & mask) != 0;
                    if (m_capture_on)
                    begin
                        m_capture = tdo ? (m_capture | mask) : (m_capture & ~mask);
                        rv = (m_bits_left == 0) || (m_bit_pos == 3'd7);
                    end
                    push_rsp(1'b1, rv, rv ? m_capture : 8'h00, rv && m_bits_left == 0);
                    if (m_bits_left == 0)
                        m_phase = jcse_pkg::PH_IDLE;
                    else if (m_bit_pos == 3'd7)
                    begin
                        m_bit_pos = '0;
                        m_need_byte = 1'b1;
                    end
                    else
                        m_bit_pos = m_bit_pos + 3'd1;
                end
            end
            jcse_pkg::PH_CLK_RUN:
            begin
                if (m_seq_step < jcse_pkg::STEP_MAIN)
                begin
                    m_tms = jcse_pkg::retry_prefix(m_seq_step);
                    m_seq_step = m_seq_step + 4'd1;
                    if (m_seq_step == jcse_pkg::STEP_MAIN && m_bits_left == 0)
                        m_seq_step = jcse_pkg::STEP_MAIN + 4'd1;
                end
                else if (m_seq_step == jcse_pkg::STEP_MAIN)
                begin
                    m_tms = 1'b0;
                    if (m_bits_left != 0)
                        m_bits_left = m_bits_left - 1;
                    if (m_bits_left == 0)
                    begin
                        if (m_retry_on)
                            m_seq_step = jcse_pkg::STEP_MAIN + 4'd1;
                        else
                            done = 1'b1;
                    end
                end
                else
                begin
                    s = int'(m_seq_step) - int'(jcse_pkg::STEP_MAIN) - 1;
                    m_tms = (s == 0);
                    m_seq_step = m_seq_step + 4'd1;
                    if (s >= 2)
                        done = 1'b1;
                end
                if (done)
                begin
                    m_phase = jcse_pkg::PH_IDLE;
                    m_seq_step = '0;
                end
                push_rsp(1'b1, done, 8'h00, done);
            end
            default: ;
        endcase
    endtask

    // response side
    always @(posedge clk)
    begin
        jcse_pkg::rsp_t exp_r;
        if (rst_n && rsp_valid && rsp_ready)
        begin
            if (expected_rsp_q.size() == 0)
            begin
                $display("%0t: unexpected response %h", $time, rsp);
                errors++;
            end
            else
            begin
                exp_r = expected_rsp_q.pop_front();
                if (rsp !== exp_r)
                begin
                    $display("%0t: mismatch expected %h actual %h", $time, exp_r, rsp);
                    errors++;
                end
            end
        end
    end

    always @(negedge clk)
    begin
        if (stall_hold)
            rsp_ready <= 1'b0;
        else if (!idle_enable)
            rsp_ready <= 1'b1;
        else
            rsp_ready <= ($urandom_range(99) >= 21);
    end

    // valid stays high between back-to-back requests; idle gaps and drain() drop it
    task automatic send_req(input logic f, input logic [7:0] b, input logic pe,
                            input logic t);
        while (idle_enable && $urandom_range(99) < 21)
        begin
            req_valid <= 1'b0;
            @(negedge clk);
        end
        req_valid <= 1'b1;
        req.func <= f;
        req.host_byte <= b;
        req.packet_end <= pe;
        req.tdo <= t;
        @(posedge clk);
        while (!req_ready)
            @(posedge clk);
        if (f)
            model_tick(t);
        else
            model_host_byte(b, pe);
        @(negedge clk);
    endtask

    task automatic host(input logic [7:0] b, input logic pe);
        send_req(1'b0, b, pe, 1'b0);
    endtask

    task automatic ticks(input int n);
        for (int i = 0; i < n; i++)
            send_req(1'b1, 8'($urandom), 1'($urandom), 1'($urandom));
    endtask

    task automatic drain();
        req_valid <= 1'b0;
        while (expected_rsp_q.size() != 0)
            @(negedge clk);
        repeat (8) @(negedge clk);
    endtask

    task automatic write_cfg(input logic v);
        drain();
        cfg_we <= 1'b1;
        cfg_wdata <= v;
        m_big_endian = v;
        @(negedge clk);
        cfg_we <= 1'b0;
    endtask

    task automatic send_count(input logic [31:0] c, input int nbytes);
        for (int i = 0; i < nbytes; i++)
        begin
            if (m_big_endian)
                host(c[8 * (nbytes - 1 - i) +: 8], 1'b0);
            else
                host(c[8 * i +: 8], 1'b0);
        end
    endtask

    task automatic cmd_move(input logic [7:0] n, input logic [7:0] pat);
        host(jcse_pkg::CMD_MOVE, 1'b0);
        host(n, 1'b0);
        host(pat, 1'b1);
        ticks(int'(n) + 1);
    endtask

    task automatic cmd_load(input logic cap, input int nbits);
        host(cap ? jcse_pkg::CMD_LOAD_CAPTURE : jcse_pkg::CMD_LOAD_IGNORE, 1'b0);
        send_count(32'(nbits), 2);
        for (int i = 0; i == 0 || i < (nbits + 7) / 8; i++)
        begin
            host(8'($urandom), i >= (nbits + 7) / 8 - 1);
            ticks((nbits - 8 * i > 8) ? 8 : ((nbits - 8 * i > 0) ? nbits - 8 * i : 1));
        end
        ticks($urandom_range(1));
    endtask

    task automatic cmd_clock(input logic [7:0] retry, input logic [31:0] n);
        host(jcse_pkg::CMD_CLOCK, 1'b0);
        host(retry, 1'b0);
        send_count(n, 4);
        host(8'($urandom), 1'b1);
        ticks(int'(n) + 11);
    endtask

    task automatic test_directed();
        host(jcse_pkg::CMD_VERSION, 1'b1);
        host(jcse_pkg::CMD_VERSION, 1'b0);
        host(8'hFF, 1'b0);
        host(8'h00, 1'b1);
        host(8'h00, 1'b1);
        cmd_move(8'd0, 8'hFF);
        cmd_move(8'd8, 8'hA5);
        cmd_load(1'b1, 0);
        cmd_load(1'b1, 13);
        cmd_load(1'b0, 9);
        cmd_clock(8'h00, 32'd0);
        cmd_clock(8'hFF, 32'd0);
        cmd_clock(8'h01, 32'd3);
        cmd_clock(8'h00, 32'd5);
    endtask

    task automatic test_random(input int n);
        int k;
        for (int i = 0; i < n; )
        begin
            k = $urandom_range(9);
            case (k)
                0: begin host(jcse_pkg::CMD_VERSION, 1'($urandom)); i++; end
                1, 2: begin cmd_move(8'($urandom_range(12)), 8'($urandom)); i += 8; end
                3, 4, 5: begin cmd_load(1'($urandom), $urandom_range(20)); i += 12; end
                6, 7: begin cmd_clock(8'($urandom_range(1)), 32'($urandom_range(6)));
                    i += 12; end
                default: begin send_req(1'($urandom), 8'($urandom), 1'($urandom),
                    1'($urandom)); i++; end
            endcase
        end
        // feed any half-parsed command two packet-end bytes, then ticks
        host(8'h00, 1'b1);
        host(8'h00, 1'b1);
        ticks(20);
    endtask

    task automatic test_backpressure();
        stall_hold = 1'b1;
        fork
            begin
                repeat (STALL_CYCLES) @(negedge clk);
                stall_hold = 1'b0;
            end
            cmd_move(8'd40, 8'h3C);
        join
    endtask

    initial
    begin
        clk = 1'b0;
        errors = 0;
        cycle_count = 0;
        stall_hold = 1'b0;
        idle_enable = 1'b0;
        rst_n = 1'b0;
        req_valid = 1'b0;
        req = '0;
        rsp_ready = 1'b1;
        cfg_we = 1'b0;
        cfg_wdata = 1'b1;
        model_reset();
        repeat (10) @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);
        test_directed();
        test_backpressure();
        idle_enable = 1'b1;
        write_cfg(1'b0);
        test_directed();
        test_random(30);
        write_cfg(1'b1);
        test_random(30);
        drain();
        if (errors == 0)
            $display("testbench OK");
        else
            $display("testbench NOT OK");
        $finish;
    end
endmodule
